// ===== rtl/dialer_detect_classifier_defines.svh =====
// Assertion macros used by the dialer classifier top level.
`ifndef DIALER_DETECT_CLASSIFIER_DEFINES_SVH
`define DIALER_DETECT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ddc_pkg.sv =====
// Types, constants and helpers for the dialer classifier.
package ddc_pkg;

  // Durations and the null-frame wait cap
  localparam int DURATION_BITS = 16;
  localparam int WAIT_CAP_MS   = 50;
  localparam int WAIT_BITS     = $clog2(2 * WAIT_CAP_MS + 1);

  typedef logic [DURATION_BITS-1:0] dur_t;
  localparam dur_t DUR_MAX = {DURATION_BITS{1'b1}};

  // Frame kinds
  typedef logic [2:0] action_t;
  localparam action_t ACT_VOICE  = 3'd0;
  localparam action_t ACT_NULL   = 3'd1;
  localparam action_t ACT_DTMF   = 3'd2;
  localparam action_t ACT_HANGUP = 3'd3;

  typedef enum logic [2:0] {
    V_HUMAN   = 3'd0,
    V_MACHINE = 3'd1,
    V_NOTSURE = 3'd2,
    V_DTMF    = 3'd3,
    V_HANGUP  = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    C_NONE       = 3'd0,
    C_TIMEOUT    = 3'd1,
    C_INIT_SIL   = 3'd2,
    C_SIL_NOISE  = 3'd3,
    C_MAX_WLEN   = 3'd4,
    C_MAX_WORDS  = 3'd5,
    C_LONG_GREET = 3'd6,
    C_DTMF       = 3'd7
  } cause_t;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_INIT_SIL    = 3'd0;
  localparam cfg_idx_t REG_GREET_LIM   = 3'd1;
  localparam cfg_idx_t REG_AFTER_GREET = 3'd2;
  localparam cfg_idx_t REG_TOTAL_TIME  = 3'd3;
  localparam cfg_idx_t REG_MIN_WLEN    = 3'd4;
  localparam cfg_idx_t REG_BETWEEN_SIL = 3'd5;
  localparam cfg_idx_t REG_MAX_WORDS   = 3'd6;
  localparam cfg_idx_t REG_MAX_WLEN    = 3'd7;

  typedef struct packed {
    logic [15:0] init_sil_ms;
    logic [15:0] greeting_limit;
    logic [15:0] after_greet_ms;
    logic [15:0] total_limit_ms;
    logic [15:0] minimum_word_length;
    logic [15:0] word_gap_ms;
    logic [7:0]  maximum_words;
    logic [15:0] max_wlen_ms;
  } cfg_t;

  typedef struct packed {
    dur_t       total_ms;
    dur_t       accumulated_silence_ms;
    dur_t       silence_ms;
    dur_t       voice_ms;
    dur_t       run_voice_ms;
    logic [7:0] word_count;
    logic       in_silence_phase;
    logic       in_initial_silence;
    logic       in_greeting;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    total_ms: '0, accumulated_silence_ms: '0, silence_ms: '0, voice_ms: '0,
    run_voice_ms: '0, word_count: '0, in_silence_phase: 1'b0,
    in_initial_silence: 1'b1, in_greeting: 1'b0};

  typedef struct packed {
    verdict_t           verdict;
    cause_t             cause;
    logic signed [16:0] measured_value;
    logic [15:0]        limit_value;
  } result_t;

  // Saturating duration add
  function automatic dur_t sat_add(dur_t a, dur_t b);
    logic [DURATION_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DURATION_BITS] ? DUR_MAX : s[DURATION_BITS-1:0];
  endfunction

  // 16-bit input value as a duration, saturating when durations are narrower
  function automatic dur_t reg_to_dur(logic [15:0] v);
    logic [DURATION_BITS+15:0] w;
    w = {{DURATION_BITS{1'b0}}, v};
    return (w > {16'd0, DUR_MAX}) ? DUR_MAX : w[DURATION_BITS-1:0];
  endfunction

  // Duration reaches a 16-bit register value, compared at full width
  function automatic logic dur_ge(dur_t d, logic [15:0] v);
    logic [DURATION_BITS+15:0] dw;
    logic [DURATION_BITS+15:0] vw;
    dw = {16'd0, d};
    vw = {{DURATION_BITS{1'b0}}, v};
    return dw >= vw;
  endfunction

  // Duration widened or cut to the 17-bit measured value
  function automatic logic [16:0] dur_to_meas(dur_t d);
    logic [DURATION_BITS+16:0] w;
    w = {17'd0, d};
    return w[16:0];
  endfunction

endpackage

// ===== rtl/ddc_cfg.sv =====
// Configuration register file of the dialer classifier.
module ddc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ddc_pkg::cfg_idx_t   cfg_index,
  input  logic [15:0]         cfg_data,
  output ddc_pkg::cfg_t       cfg_o
);

  ddc_pkg::cfg_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = regs_r;

  // Register write decode
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        ddc_pkg::REG_INIT_SIL:    regs_nxt.init_sil_ms         = cfg_data;
        ddc_pkg::REG_GREET_LIM:   regs_nxt.greeting_limit      = cfg_data;
        ddc_pkg::REG_AFTER_GREET: regs_nxt.after_greet_ms      = cfg_data;
        ddc_pkg::REG_TOTAL_TIME:  regs_nxt.total_limit_ms      = cfg_data;
        ddc_pkg::REG_MIN_WLEN:    regs_nxt.minimum_word_length = cfg_data;
        ddc_pkg::REG_BETWEEN_SIL: regs_nxt.word_gap_ms         = cfg_data;
        ddc_pkg::REG_MAX_WORDS:   regs_nxt.maximum_words       = cfg_data[7:0];
        ddc_pkg::REG_MAX_WLEN:    regs_nxt.max_wlen_ms         = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{init_sil_ms: 16'd2500, greeting_limit: 16'd1500,
                  after_greet_ms: 16'd800, total_limit_ms: 16'd5000,
                  minimum_word_length: 16'd100, word_gap_ms: 16'd50,
                  maximum_words: 8'd3, max_wlen_ms: 16'd5000};
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== rtl/ddc_core.sv =====
// Per-frame decision logic: next state and optional verdict.
module ddc_core (
  input  ddc_pkg::cfg_t    cfg_i,
  input  ddc_pkg::state_t  state_i,
  input  ddc_pkg::action_t action,
  input  logic [15:0]      frame_ms,
  input  logic [15:0]      detected_silence_ms,
  input  logic [7:0]       dtmf_code,
  output ddc_pkg::state_t  state_o,
  output logic             emit_o,
  output ddc_pkg::result_t result_o
);

  logic [15:0]     wait_ms;
  ddc_pkg::dur_t   null_ms;
  ddc_pkg::dur_t   flen;
  ddc_pkg::dur_t   tot;
  ddc_pkg::dur_t   acc;
  ddc_pkg::dur_t   run_v;
  ddc_pkg::dur_t   voice_v;
  logic [7:0]      wc;
  logic            word_hit;
  ddc_pkg::state_t st;

  // Frame wait: smallest of the cap and six registers
  always_comb begin
    wait_ms = 16'(ddc_pkg::WAIT_CAP_MS);
    if (cfg_i.init_sil_ms         < wait_ms) wait_ms = cfg_i.init_sil_ms;
    if (cfg_i.greeting_limit      < wait_ms) wait_ms = cfg_i.greeting_limit;
    if (cfg_i.after_greet_ms      < wait_ms) wait_ms = cfg_i.after_greet_ms;
    if (cfg_i.total_limit_ms      < wait_ms) wait_ms = cfg_i.total_limit_ms;
    if (cfg_i.minimum_word_length < wait_ms) wait_ms = cfg_i.minimum_word_length;
    if (cfg_i.word_gap_ms         < wait_ms) wait_ms = cfg_i.word_gap_ms;
  end

  assign null_ms  = ddc_pkg::dur_t'({wait_ms[ddc_pkg::WAIT_BITS-2:0], 1'b0});
  assign flen     = (action == ddc_pkg::ACT_VOICE) ? ddc_pkg::reg_to_dur(frame_ms) : null_ms;
  assign tot      = ddc_pkg::sat_add(state_i.total_ms, flen);
  assign acc      = (action == ddc_pkg::ACT_NULL) ?
                    ddc_pkg::sat_add(state_i.accumulated_silence_ms, null_ms) :
                    ddc_pkg::reg_to_dur(detected_silence_ms);
  assign run_v    = ddc_pkg::sat_add(state_i.run_voice_ms, flen);
  assign voice_v  = ddc_pkg::sat_add(state_i.voice_ms, flen);
  assign word_hit = ddc_pkg::dur_ge(run_v, cfg_i.minimum_word_length) &&
                    state_i.in_silence_phase;
  assign wc       = (word_hit && state_i.word_count != 8'hFF) ?
                    state_i.word_count + 8'd1 : state_i.word_count;

  // Decision tree, in priority order
  always_comb begin
    st       = state_i;
    emit_o   = 1'b0;
    result_o = '{verdict: ddc_pkg::V_HUMAN, cause: ddc_pkg::C_NONE,
                 measured_value: '0, limit_value: '0};
    if (action == ddc_pkg::ACT_HANGUP) begin
      emit_o           = 1'b1;
      result_o.verdict = ddc_pkg::V_HANGUP;
    end else if (action == ddc_pkg::ACT_DTMF) begin
      emit_o                  = 1'b1;
      result_o.verdict        = ddc_pkg::V_DTMF;
      result_o.cause          = ddc_pkg::C_DTMF;
      result_o.measured_value = $signed({9'd0, dtmf_code} - 17'd48);
    end else if (action == ddc_pkg::ACT_VOICE || action == ddc_pkg::ACT_NULL) begin
      st.total_ms = tot;
      if (ddc_pkg::dur_ge(tot, cfg_i.total_limit_ms)) begin
        emit_o                  = 1'b1;
        result_o.verdict        = ddc_pkg::V_NOTSURE;
        result_o.cause          = ddc_pkg::C_TIMEOUT;
        result_o.measured_value = $signed(ddc_pkg::dur_to_meas(tot));
      end else begin
        st.accumulated_silence_ms = acc;
        if (acc != '0) begin
          // Silence side
          st.silence_ms = acc;
          if (ddc_pkg::dur_ge(acc, cfg_i.word_gap_ms)) begin
            st.in_silence_phase = 1'b1;
            st.run_voice_ms     = '0;
          end
          if (state_i.in_initial_silence && ddc_pkg::dur_ge(acc, cfg_i.init_sil_ms)) begin
            emit_o                  = 1'b1;
            result_o.verdict        = ddc_pkg::V_HUMAN;
            result_o.cause          = ddc_pkg::C_INIT_SIL;
            result_o.measured_value = $signed(ddc_pkg::dur_to_meas(acc));
            result_o.limit_value    = cfg_i.init_sil_ms;
          end else if (state_i.in_greeting &&
                       ddc_pkg::dur_ge(acc, cfg_i.after_greet_ms)) begin
            emit_o                  = 1'b1;
            result_o.verdict        = ddc_pkg::V_HUMAN;
            result_o.cause          = ddc_pkg::C_SIL_NOISE;
            result_o.measured_value = $signed(ddc_pkg::dur_to_meas(acc));
            result_o.limit_value    = cfg_i.after_greet_ms;
          end
        end else begin
          // Voice side
          st.run_voice_ms = run_v;
          st.voice_ms     = voice_v;
          st.word_count   = wc;
          if (word_hit) st.in_silence_phase = 1'b0;
          if (ddc_pkg::dur_ge(run_v, cfg_i.max_wlen_ms)) begin
            emit_o                  = 1'b1;
            result_o.verdict        = ddc_pkg::V_MACHINE;
            result_o.cause          = ddc_pkg::C_MAX_WLEN;
            result_o.measured_value = $signed(ddc_pkg::dur_to_meas(run_v));
          end else if (wc >= cfg_i.maximum_words) begin
            emit_o                  = 1'b1;
            result_o.verdict        = ddc_pkg::V_MACHINE;
            result_o.cause          = ddc_pkg::C_MAX_WORDS;
            result_o.measured_value = $signed({9'd0, wc});
            result_o.limit_value    = {8'd0, cfg_i.maximum_words};
          end else if (state_i.in_greeting &&
                       ddc_pkg::dur_ge(voice_v, cfg_i.greeting_limit)) begin
            emit_o                  = 1'b1;
            result_o.verdict        = ddc_pkg::V_MACHINE;
            result_o.cause          = ddc_pkg::C_LONG_GREET;
            result_o.measured_value = $signed(ddc_pkg::dur_to_meas(voice_v));
            result_o.limit_value    = cfg_i.greeting_limit;
          end else begin
            if (ddc_pkg::dur_ge(voice_v, cfg_i.minimum_word_length)) st.silence_ms = '0;
            if (ddc_pkg::dur_ge(run_v, cfg_i.minimum_word_length) && !state_i.in_greeting) begin
              st.in_initial_silence = 1'b0;
              st.in_greeting        = 1'b1;
            end
          end
        end
      end
    end
    // Any verdict restarts the analysis
    state_o = emit_o ? ddc_pkg::STATE_CLEAR : st;
  end

endmodule

// ===== rtl/dialer_detect_classifier.sv =====
// Top level of the dialer classifier: input stage, state, result register.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tuser action, tdata frame/silence/dtmf
//  out_    | master    | out_tvalid/tready  | tdata verdict/cause/measured/limit
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per cycle while out_ does not stall: an item waits in the input register, then the
// decision logic updates state and loads the result register in one step.
// The result register drives out_; an item's result is loaded there as the item leaves the input register.
// rst_n (synchronous) restores register defaults and clears analysis state.
// A stalled result holds the decision stage; the input register still takes
// one more item behind it.
`include "dialer_detect_classifier_defines.svh"

module dialer_detect_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // frame_ms[15:0], detected_silence_ms[31:16], dtmf_code[39:32]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // verdict[2:0], cause[5:3], measured_value[22:6],
                                  // limit_value[38:23], zero[39]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ddc_pkg::cfg_t    cfg;
  ddc_pkg::state_t  state_r, state_nxt;
  ddc_pkg::result_t res, out_res_r;
  logic             emit;
  logic             in_valid_r;
  ddc_pkg::action_t in_action_r;
  logic [15:0]      in_frame_r, in_det_r;
  logic [7:0]       in_dtmf_r;
  logic             out_valid_r;
  logic             fire;

  ddc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ddc_core u_core (
    .cfg_i               (cfg),
    .state_i             (state_r),
    .action              (in_action_r),
    .frame_ms            (in_frame_r),
    .detected_silence_ms (in_det_r),
    .dtmf_code           (in_dtmf_r),
    .state_o             (state_nxt),
    .emit_o              (emit),
    .result_o            (res)
  );

  // Stage handshakes
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_action_r <= in_tuser;
      in_frame_r  <= in_tdata[15:0];
      in_det_r    <= in_tdata[31:16];
      in_dtmf_r   <= in_tdata[39:32];
    end
  end

  // Analysis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddc_pkg::STATE_CLEAR;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.limit_value, out_res_r.measured_value,
                       out_res_r.cause, out_res_r.verdict};

  // Checks
  `DDC_ASSERT_NXT(a_emit_shows, fire && emit, out_tvalid, "verdict not presented")
  `DDC_ASSERT_NXT(a_emit_clears, fire && emit,
                  state_r.total_ms == '0 && state_r.in_initial_silence &&
                  !state_r.in_greeting && state_r.word_count == 8'd0,
                  "state not cleared after verdict")
  `DDC_ASSERT_IMP(a_stall_full, !in_tready, in_valid_r && out_valid_r && !out_tready,
                  "input stalled without cause")
  `DDC_ASSERT_NXT(a_other_quiet,
                  fire && in_action_r != ddc_pkg::ACT_VOICE &&
                  in_action_r != ddc_pkg::ACT_NULL && in_action_r != ddc_pkg::ACT_DTMF &&
                  in_action_r != ddc_pkg::ACT_HANGUP,
                  $stable(state_r) && !out_tvalid, "ignored frame changed state")

endmodule

// ===== tb/tb_dialer_detect_classifier.sv =====
// Self-checking testbench for the dialer classifier: directed frames, then random calls.
module tb_dialer_detect_classifier;
  import ddc_pkg::*;

  // Frame kinds that the block ignores
  localparam action_t ACT_OTHER_LO = 3'd4;
  localparam action_t ACT_OTHER_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  typedef logic [15:0] setting_t [8];
  localparam setting_t DEFAULT_LIMITS = '{16'd2500, 16'd1500, 16'd800, 16'd5000,
                                          16'd100, 16'd50, 16'd3, 16'd5000};
  localparam setting_t SMALL_LIMITS = '{16'd300, 16'd200, 16'd150, 16'd1000,
                                        16'd40, 16'd20, 16'd2, 16'd250};
  localparam setting_t MIN_LIMITS = '{16'd1, 16'd1, 16'd1, 16'd1,
                                      16'd1, 16'd1, 16'd1, 16'd1};
  localparam setting_t MAX_LIMITS = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF};

  typedef struct packed {
    action_t     action;
    logic [15:0] frame_ms;
    logic [15:0] silence_ms;
    logic [7:0]  code;
  } frame_t;

  typedef struct packed {
    verdict_t    verdict;
    cause_t      cause;
    logic [16:0] measured;
    logic [15:0] limit;
  } outcome_t;

  typedef struct packed {
    logic [15:0] total_ms;
    logic [15:0] acc_sil_ms;
    logic [15:0] sil_ms;
    logic [15:0] voice_ms;
    logic [15:0] run_ms;
    logic [7:0]  words;
    logic        sil_phase;
    logic        init_phase;
    logic        greeting;
  } call_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    outcome_t o;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dialer_detect_classifier dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of registers and call state
  logic [15:0] limits [8] = DEFAULT_LIMITS;
  call_t       call_st;
  outcome_t    expected_verdicts[$];
  dir_row_t    dir_rows[$];

  int errors = 0;
  int frames_sent = 0;
  int verdicts_seen = 0;
  int cause_hits [8] = '{default: 0};
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] clip_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void clear_call();
    call_st = '0;
    call_st.init_phase = 1'b1;
  endfunction

  // Record a verdict and start a fresh call
  function automatic void conclude(output outcome_t o, input verdict_t v, input cause_t c,
                                   input logic [16:0] m, input logic [15:0] l);
    o = '{verdict: v, cause: c, measured: m, limit: l};
    clear_call();
  endfunction

  // Advances the call by one frame; returns 1 when a verdict comes out
  function automatic bit classify_frame(input frame_t f, output outcome_t o);
    logic [15:0] wait_ms;
    logic [15:0] flen;
    o = '{verdict: V_HUMAN, cause: C_NONE, measured: 17'd0, limit: 16'd0};
    if (f.action == ACT_HANGUP) begin
      conclude(o, V_HANGUP, C_NONE, 17'd0, 16'd0);
      return 1'b1;
    end
    if (f.action == ACT_DTMF) begin
      conclude(o, V_DTMF, C_DTMF, {9'd0, f.code} - 17'd48, 16'd0);
      return 1'b1;
    end
    if (f.action != ACT_VOICE && f.action != ACT_NULL) return 1'b0;

    // null frames last twice the shortest timing register, capped
    wait_ms = 16'(WAIT_CAP_MS);
    for (int r = REG_INIT_SIL; r <= REG_BETWEEN_SIL; r++)
      if (limits[r] < wait_ms) wait_ms = limits[r];
    flen = (f.action == ACT_VOICE) ? f.frame_ms : {wait_ms[14:0], 1'b0};

    call_st.total_ms = clip_add(call_st.total_ms, flen);
    if (call_st.total_ms >= limits[REG_TOTAL_TIME]) begin
      conclude(o, V_NOTSURE, C_TIMEOUT, {1'b0, call_st.total_ms}, 16'd0);
      return 1'b1;
    end

    if (f.action == ACT_NULL) call_st.acc_sil_ms = clip_add(call_st.acc_sil_ms, flen);
    else call_st.acc_sil_ms = f.silence_ms;

    if (call_st.acc_sil_ms != 16'd0) begin
      call_st.sil_ms = call_st.acc_sil_ms;
      if (call_st.sil_ms >= limits[REG_BETWEEN_SIL]) begin
        call_st.sil_phase = 1'b1;
        call_st.run_ms = 16'd0;
      end
      if (call_st.init_phase && call_st.sil_ms >= limits[REG_INIT_SIL]) begin
        conclude(o, V_HUMAN, C_INIT_SIL, {1'b0, call_st.sil_ms}, limits[REG_INIT_SIL]);
        return 1'b1;
      end
      if (call_st.greeting && call_st.sil_ms >= limits[REG_AFTER_GREET]) begin
        conclude(o, V_HUMAN, C_SIL_NOISE, {1'b0, call_st.sil_ms}, limits[REG_AFTER_GREET]);
        return 1'b1;
      end
    end else begin
      call_st.run_ms = clip_add(call_st.run_ms, flen);
      call_st.voice_ms = clip_add(call_st.voice_ms, flen);
      // a word: enough voice after a silence
      if (call_st.run_ms >= limits[REG_MIN_WLEN] && call_st.sil_phase) begin
        if (call_st.words != 8'hFF) call_st.words = call_st.words + 8'd1;
        call_st.sil_phase = 1'b0;
      end
      if (call_st.run_ms >= limits[REG_MAX_WLEN]) begin
        conclude(o, V_MACHINE, C_MAX_WLEN, {1'b0, call_st.run_ms}, 16'd0);
        return 1'b1;
      end
      if ({8'd0, call_st.words} >= limits[REG_MAX_WORDS]) begin
        conclude(o, V_MACHINE, C_MAX_WORDS, {9'd0, call_st.words}, limits[REG_MAX_WORDS]);
        return 1'b1;
      end
      if (call_st.greeting && call_st.voice_ms >= limits[REG_GREET_LIM]) begin
        conclude(o, V_MACHINE, C_LONG_GREET, {1'b0, call_st.voice_ms}, limits[REG_GREET_LIM]);
        return 1'b1;
      end
      if (call_st.voice_ms >= limits[REG_MIN_WLEN]) call_st.sil_ms = 16'd0;
      if (call_st.run_ms >= limits[REG_MIN_WLEN] && !call_st.greeting) begin
        call_st.init_phase = 1'b0;
        call_st.greeting = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t row(action_t a, int fm, int sm, int cd);
    dir_row_t d;
    d.f = '{action: a, frame_ms: 16'(fm), silence_ms: 16'(sm), code: 8'(cd)};
    d.typed = 1'b0;
    d.o = '{verdict: V_HUMAN, cause: C_NONE, measured: 17'd0, limit: 16'd0};
    return d;
  endfunction

  function automatic dir_row_t row_exp(action_t a, int fm, int sm, int cd,
                                       verdict_t v, cause_t c, int m, int l);
    dir_row_t d;
    d = row(a, fm, sm, cd);
    d.typed = 1'b1;
    d.o = '{verdict: v, cause: c, measured: 17'(m), limit: 16'(l)};
    return d;
  endfunction

  // Random frame, sized against the current registers so calls reach deep states
  function automatic frame_t random_frame();
    frame_t f;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    f.frame_ms = 16'($urandom_range(0, limits[REG_TOTAL_TIME] / 12 + 4));
    f.silence_ms = 16'($urandom);
    f.code = 8'($urandom);
    if (pick < 3) f.action = ACT_HANGUP;
    else if (pick < 6) f.action = ACT_DTMF;
    else if (pick < 9) f.action = action_t'($urandom_range(ACT_OTHER_LO, ACT_OTHER_HI));
    else if (pick < 22) f.action = ACT_NULL;
    else begin
      f.action = ACT_VOICE;
      pick = $urandom_range(0, 99);
      if (pick < 4) f.frame_ms = 16'($urandom);
      else if (pick < 55) f.silence_ms = 16'd0;
      else begin
        if (pick < 75) span = limits[REG_BETWEEN_SIL] * 2 + 1;
        else if (pick < 90) span = limits[REG_AFTER_GREET] + limits[REG_AFTER_GREET] / 4 + 1;
        else span = limits[REG_INIT_SIL] + limits[REG_INIT_SIL] / 4 + 1;
        f.silence_ms = 16'($urandom_range(1, span > 65535 ? 65535 : span));
      end
    end
    return f;
  endfunction

  // Offer one frame, wait for acceptance, queue what it should produce
  task automatic send_frame(frame_t f, bit typed, outcome_t typed_o);
    outcome_t o;
    bit got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {f.code, f.silence_ms, f.frame_ms};
    in_tuser <= f.action;
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    got = classify_frame(f, o);
    if (typed) o = typed_o;
    if (got || typed) expected_verdicts.push_back(o);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all registers; the block is idle when this is called
  task automatic apply_setting(setting_t s);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= s[i];
      do @(posedge clk); while (!cfg_ready);
      limits[i] = (cfg_idx_t'(i) == REG_MAX_WORDS) ? {8'd0, s[i][7:0]} : s[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct);
    outcome_t none;
    none = '{verdict: V_HUMAN, cause: C_NONE, measured: 17'd0, limit: 16'd0};
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    repeat (n) send_frame(random_frame(), 1'b0, none);
  endtask

  function automatic void note_mismatch(string what, outcome_t want, logic [39:0] got);
    errors++;
    if (errors <= 10)
      $display("%s: expected v=%0d c=%0d m=%0d l=%0d, got v=%0d c=%0d m=%0d l=%0d", what,
               want.verdict, want.cause, $signed(want.measured), want.limit,
               got[2:0], got[5:3], $signed(got[22:6]), got[38:23]);
  endfunction

  // Result receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each verdict with the oldest expectation
  always @(posedge clk) begin : check_verdicts
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen++;
      cause_hits[out_tdata[5:3]]++;
      if (expected_verdicts.size() == 0) begin
        want = '{verdict: V_HUMAN, cause: C_NONE, measured: 17'd0, limit: 16'd0};
        note_mismatch("unexpected verdict", want, out_tdata);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tdata[2:0] != want.verdict || out_tdata[5:3] != want.cause ||
            out_tdata[22:6] != want.measured || out_tdata[38:23] != want.limit)
          note_mismatch("verdict mismatch", want, out_tdata);
      end
    end
  end

  // Watchdog: too long with no item moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("tb_dialer_detect_classifier: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    setting_t rnd;
    outcome_t left;
    clear_call();

    // Directed frames under the reset register values
    dir_rows.push_back(row_exp(ACT_HANGUP, 0, 0, 0, V_HANGUP, C_NONE, 0, 0));
    dir_rows.push_back(row_exp(ACT_DTMF, 0, 0, 0, V_DTMF, C_DTMF, -48, 0));
    dir_rows.push_back(row_exp(ACT_DTMF, 65535, 65535, 255, V_DTMF, C_DTMF, 207, 0));
    dir_rows.push_back(row_exp(ACT_DTMF, 0, 0, 53, V_DTMF, C_DTMF, 5, 0));
    dir_rows.push_back(row(ACT_OTHER_LO, 100, 0, 0));
    dir_rows.push_back(row(ACT_OTHER_HI, 65535, 65535, 255));
    dir_rows.push_back(row_exp(ACT_VOICE, 65535, 0, 0, V_NOTSURE, C_TIMEOUT, 65535, 0));
    dir_rows.push_back(row_exp(ACT_VOICE, 20, 2500, 0, V_HUMAN, C_INIT_SIL, 2500, 2500));
    dir_rows.push_back(row_exp(ACT_VOICE, 20, 65535, 0, V_HUMAN, C_INIT_SIL, 65535, 2500));
    // greeting, then a silence after it
    dir_rows.push_back(row(ACT_VOICE, 200, 0, 0));
    dir_rows.push_back(row(ACT_VOICE, 20, 900, 0));
    // greeting that runs too long
    dir_rows.push_back(row(ACT_VOICE, 200, 0, 0));
    dir_rows.push_back(row(ACT_VOICE, 1400, 0, 0));
    // three words, one of them after comfort noise
    dir_rows.push_back(row(ACT_VOICE, 200, 0, 0));
    dir_rows.push_back(row(ACT_VOICE, 20, 60, 0));
    dir_rows.push_back(row(ACT_VOICE, 100, 0, 0));
    dir_rows.push_back(row(ACT_NULL, 0, 0, 0));
    dir_rows.push_back(row(ACT_VOICE, 100, 0, 0));
    dir_rows.push_back(row(ACT_VOICE, 20, 60, 0));
    dir_rows.push_back(row(ACT_VOICE, 100, 0, 0));
    dir_rows.push_back(row_exp(ACT_VOICE, 5000, 0, 0, V_NOTSURE, C_TIMEOUT, 5000, 0));
    dir_rows.push_back(row(ACT_VOICE, 0, 0, 0));
    dir_rows.push_back(row_exp(ACT_HANGUP, 0, 0, 0, V_HANGUP, C_NONE, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].o);
    run_phase(150, 0, 0);

    drain_results();
    apply_setting(SMALL_LIMITS);
    run_phase(160, 74, 0);

    drain_results();
    apply_setting(MIN_LIMITS);
    run_phase(150, 0, 74);

    // Long receiver hold-off fills the block; then a pause until all verdicts are out
    drain_results();
    apply_setting(MAX_LIMITS);
    hold_start = 1'b1;
    run_phase(80, 14, 14);
    drain_results();
    run_phase(80, 14, 14);

    drain_results();
    foreach (rnd[i]) rnd[i] = 16'($urandom_range(20, 3000));
    rnd[REG_MAX_WORDS] = 16'($urandom_range(1, 6));
    apply_setting(rnd);
    run_phase(160, 0, 0);

    drain_results();
    apply_setting(DEFAULT_LIMITS);
    run_phase(150, 74, 74);

    drain_results();
    while (expected_verdicts.size() != 0) begin
      left = expected_verdicts.pop_front();
      note_mismatch("missing verdict", left, 40'd0);
    end

    $display("covered %0d frames and %0d verdicts under 6 register settings, idle and stalled",
             frames_sent, verdicts_seen);
    $display("causes: none %0d timeout %0d init-sil %0d sil-after %0d wlen %0d words %0d greet %0d dtmf %0d",
             cause_hits[C_NONE], cause_hits[C_TIMEOUT], cause_hits[C_INIT_SIL],
             cause_hits[C_SIL_NOISE], cause_hits[C_MAX_WLEN], cause_hits[C_MAX_WORDS],
             cause_hits[C_LONG_GREET], cause_hits[C_DTMF]);
    if (errors == 0) begin
      $display("tb_dialer_detect_classifier: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_dialer_detect_classifier: FAIL");
    end
    $finish;
  end

endmodule

// ===== dialer_detect_classifier.f =====
+incdir+rtl
rtl/ddc_pkg.sv
rtl/ddc_cfg.sv
rtl/ddc_core.sv
rtl/dialer_detect_classifier.sv
tb/tb_dialer_detect_classifier.sv
